// ----- hw/rtl/clnw_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clnw_pkg: shared types and constants
// Command codes, LCD instruction bytes and the job record that is passed
// from the front end to the nibble serializer.
// ----------------------------------------------------------------------------
package clnw_pkg;

    typedef enum logic [1:0] {
        CMD_PRINT   = 2'd0,
        CMD_SET_POS = 2'd1,
        CMD_CLEAR   = 2'd2,
        CMD_GLYPH   = 2'd3
    } t_cmd;

    localparam logic [7:0] LCD_CLEAR    = 8'h01;
    localparam logic [7:0] LCD_RET_HOME = 8'h02;
    localparam logic [7:0] LCD_DDRAM    = 8'h80;
    localparam logic [7:0] LCD_CGRAM    = 8'h40;
    localparam logic [7:0] LCD_LINE2    = LCD_DDRAM | LCD_CGRAM;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] LINE1_LAST   = 8'd15;

    localparam int MAX_BYTES = 5;
    localparam int CNT_W     = $clog2(MAX_BYTES + 1);
    localparam int IDX_W     = $clog2(2 * MAX_BYTES);

    localparam int Q_DEPTH = 4;
    localparam int QPTR_W  = $clog2(Q_DEPTH);
    localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [MAX_BYTES-1:0]      rs;
        logic [CNT_W-1:0]          count;
    } t_job;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

endpackage : clnw_pkg
`default_nettype wire

// ----- hw/rtl/char_lcd_nibble_writer_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// char_lcd_nibble_writer_top: 4-bit character LCD command writer
// Turns print / set-position / clear / glyph-row commands into nibble
// transfers for a character LCD on a 4-bit bus.
//
// Input channel: i_in_valid / o_in_stall carry one command item
// (cmd, value, position, glyph_slot, glyph_row). Output channel:
// o_out_valid / i_out_stall carry one nibble transfer (reg_select,
// nibble, last); last marks the final nibble of an item.
// An item causes 0 to 8 nibbles. The front end takes one item per
// cycle while the queue is not full and updates cursor and pending-clear
// state at once; jobs wait in a 4-entry queue. The first nibble of an
// item passes through the queue and then the output register; after it,
// one nibble per cycle follows while the receiver does not stall. The
// output register is the rate limit.
// o_in_stall rises only when the queue is full. When the receiver
// stalls, the current nibble holds and the queue fills up behind it.
// Reset empties the queue, drops the output and zeroes cursor and
// pending-clear state.
// ----------------------------------------------------------------------------
module char_lcd_nibble_writer_top
    import clnw_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [1:0] i_cmd,
    input  wire logic [7:0] i_value,
    input  wire logic [4:0] i_position,
    input  wire logic [2:0] i_glyph_slot,
    input  wire logic [2:0] i_glyph_row,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic            o_reg_select,
    output logic [3:0]      o_nibble,
    output logic            o_last
);

    t_job      front_job;
    t_job      head_job;
    t_q_status q_status;
    logic      push;
    logic      pop;
    logic      in_accept;

    assign o_in_stall = q_status.full;
    assign in_accept  = i_in_valid && !o_in_stall;

    clnw_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (in_accept),
        .i_cmd        (i_cmd),
        .i_value      (i_value),
        .i_position   (i_position),
        .i_glyph_slot (i_glyph_slot),
        .i_glyph_row  (i_glyph_row),
        .o_job        (front_job),
        .o_push       (push)
    );

    clnw_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (front_job),
        .i_pop    (pop),
        .o_head   (head_job),
        .o_status (q_status)
    );

    clnw_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head_job),
        .i_status     (q_status),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_reg_select (o_reg_select),
        .o_nibble     (o_nibble),
        .o_last       (o_last)
    );

    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_status.full)
        else $error("job pushed into full queue");

    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_status.empty)
        else $error("job popped from empty queue");

    a_stall_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (!q_status.empty && o_out_valid))
        else $error("input stalled with nothing in flight");

    a_reset_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !o_out_valid)
        else $error("output valid right after reset");

endmodule : char_lcd_nibble_writer_top
`default_nettype wire

// ----- hw/rtl/clnw_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clnw_front: command decode and cursor tracking
// Accepts one item per cycle while i_accept is high, updates cursor and
// pending-clear state and builds the list of LCD bytes the item causes.
// ----------------------------------------------------------------------------
module clnw_front
    import clnw_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [1:0] i_cmd,
    input  wire logic [7:0] i_value,
    input  wire logic [4:0] i_position,
    input  wire logic [2:0] i_glyph_slot,
    input  wire logic [2:0] i_glyph_row,
    output t_job            o_job,
    output logic            o_push
);

    logic [7:0] r_cursor, n_cursor;
    logic       r_pending, n_pending;
    t_job       job;
    logic       is_nl;

    always_comb begin
        job       = '0;
        n_cursor  = r_cursor;
        n_pending = r_pending;
        is_nl     = (i_value == CHAR_NEWLINE);
        unique case (t_cmd'(i_cmd))
            CMD_PRINT: begin
                if (r_pending) begin
                    job.bytes[0] = LCD_CLEAR;
                    job.bytes[1] = LCD_RET_HOME;
                    job.bytes[2] = LCD_DDRAM;
                    if (is_nl) begin
                        job.count = CNT_W'(3);
                        n_cursor  = '0;
                    end else begin
                        job.bytes[3] = i_value;
                        job.rs[3]    = 1'b1;
                        job.count    = CNT_W'(4);
                        n_cursor     = 8'd1;
                        n_pending    = 1'b0;
                    end
                end else if (is_nl) begin
                    n_pending = 1'b1;
                    n_cursor  = '0;
                end else begin
                    job.bytes[0] = i_value;
                    job.rs[0]    = 1'b1;
                    if (r_cursor == LINE1_LAST) begin
                        job.bytes[1] = LCD_LINE2;
                        job.count    = CNT_W'(2);
                    end else begin
                        job.count    = CNT_W'(1);
                    end
                    n_cursor = r_cursor + 8'd1;
                end
            end
            CMD_SET_POS: begin
                job.bytes[0] = LCD_DDRAM | {1'b0, i_position[4], 2'b00, i_position[3:0]};
                job.count    = CNT_W'(1);
                n_cursor     = {3'b000, i_position};
            end
            CMD_CLEAR: begin
                job.bytes[0] = LCD_CLEAR;
                job.bytes[1] = LCD_RET_HOME;
                job.count    = CNT_W'(2);
                n_cursor     = '0;
            end
            CMD_GLYPH: begin
                job.bytes[0] = LCD_CGRAM | {2'b00, i_glyph_slot, i_glyph_row};
                job.bytes[1] = i_value;
                job.rs[1]    = 1'b1;
                job.count    = CNT_W'(2);
            end
            default: begin
                job = '0;
            end
        endcase
    end

    assign o_job  = job;
    assign o_push = i_accept && (job.count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor  <= '0;
            r_pending <= 1'b0;
        end else if (i_accept) begin
            r_cursor  <= n_cursor;
            r_pending <= n_pending;
        end
    end

endmodule : clnw_front
`default_nettype wire

// ----- hw/rtl/clnw_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clnw_queue: job queue
// Small FIFO of byte jobs between the front end and the serializer.
// ----------------------------------------------------------------------------
module clnw_queue
    import clnw_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    input  wire logic i_pop,
    output t_job      o_head,
    output t_q_status o_status
);

    t_job              r_mem [Q_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;

    assign o_head         = r_mem[r_rptr];
    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == QCNT_W'(Q_DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule : clnw_queue
`default_nettype wire

// ----- hw/rtl/clnw_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clnw_back: nibble serializer
// Walks the head job byte by byte, high nibble first, into a registered
// output stage; retires the job on its final nibble.
// ----------------------------------------------------------------------------
module clnw_back
    import clnw_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_job      i_head,
    input  wire t_q_status i_status,
    output logic      o_pop,
    output logic      o_out_valid,
    input  wire logic i_out_stall,
    output logic      o_reg_select,
    output logic [3:0] o_nibble,
    output logic      o_last
);

    logic [IDX_W-1:0] r_idx;
    logic             r_out_valid;
    logic             r_rs;
    logic [3:0]       r_nib;
    logic             r_last;

    logic             advance;
    logic             is_last;
    logic [7:0]       cur_byte;
    logic             cur_rs;

    always_comb begin
        cur_byte = i_head.bytes[0];
        cur_rs   = i_head.rs[0];
        case (r_idx[IDX_W-1:1])
            3'd1: begin
                cur_byte = i_head.bytes[1];
                cur_rs   = i_head.rs[1];
            end
            3'd2: begin
                cur_byte = i_head.bytes[2];
                cur_rs   = i_head.rs[2];
            end
            3'd3: begin
                cur_byte = i_head.bytes[3];
                cur_rs   = i_head.rs[3];
            end
            3'd4: begin
                cur_byte = i_head.bytes[4];
                cur_rs   = i_head.rs[4];
            end
            default: begin
                cur_byte = i_head.bytes[0];
                cur_rs   = i_head.rs[0];
            end
        endcase
    end

    assign advance = !i_status.empty && (!r_out_valid || !i_out_stall);
    assign is_last = (r_idx == ({i_head.count, 1'b0} - IDX_W'(1)));
    assign o_pop   = advance && is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
            r_idx       <= is_last ? '0 : r_idx + 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_rs   <= cur_rs;
            r_nib  <= r_idx[0] ? cur_byte[3:0] : cur_byte[7:4];
            r_last <= is_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_reg_select = r_rs;
    assign o_nibble     = r_nib;
    assign o_last       = r_last;

endmodule : clnw_back
`default_nettype wire

// ----- tb/tb_char_lcd_nibble_writer_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_char_lcd_nibble_writer_top: self-checking bench for the LCD nibble writer
// Feeds print, set-position, clear and glyph-row items through the input
// channel and checks every nibble transfer against a cycle-free model of
// the cursor and pending-clear state. It covers directed corner items, a
// long print run that wraps the cursor past 255 while the receiver holds
// off, and a random command mix. The input idles and the receiver stalls at random.
// ----------------------------------------------------------------------------
module tb_char_lcd_nibble_writer_top;
    import clnw_pkg::*;

    localparam int         LIMIT        = 200000;
    localparam int         LONG_HOLD    = 300;
    localparam int         DRAIN_CYCLES = 40;
    localparam int         WRAP_PRINTS  = 258;
    localparam int         MIX_ITEMS    = 150;
    localparam logic [7:0] LINE2_OFFSET = 8'h30;

    typedef struct packed {
        logic       rs;
        logic [3:0] nib;
        logic       last;
    } t_lcd_xfer;

    class lcd_nibble_scoreboard;
        t_lcd_xfer  expected_q[$];
        logic [7:0] cursor;
        logic       clear_armed;
        int         errors;
        int         items_seen;
        int         nibbles_seen;
        int         line2_jumps;
        int         clears_flushed;

        function new();
            cursor         = 8'd0;
            clear_armed    = 1'b0;
            errors         = 0;
            items_seen     = 0;
            nibbles_seen   = 0;
            line2_jumps    = 0;
            clears_flushed = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void push_byte(logic rs, logic [7:0] b);
            expected_q.push_back('{rs: rs, nib: b[7:4], last: 1'b0});
            expected_q.push_back('{rs: rs, nib: b[3:0], last: 1'b0});
        endfunction

        function void note_item(t_cmd cmd, logic [7:0] value, logic [4:0] pos,
                                logic [2:0] slot, logic [2:0] row);
            int start_size;
            start_size = expected_q.size();
            items_seen++;
            case (cmd)
                CMD_PRINT: begin
                    if (clear_armed) begin
                        push_byte(1'b0, LCD_CLEAR);
                        push_byte(1'b0, LCD_RET_HOME);
                        push_byte(1'b0, LCD_DDRAM);
                        cursor      = 8'd0;
                        clear_armed = 1'b0;
                        clears_flushed++;
                    end
                    if (value == CHAR_NEWLINE) begin
                        clear_armed = 1'b1;
                        cursor      = 8'd0;
                    end else begin
                        push_byte(1'b1, value);
                        if (cursor == LINE1_LAST) begin
                            push_byte(1'b0, LCD_LINE2);
                            line2_jumps++;
                        end
                        cursor = cursor + 8'd1;
                    end
                end
                CMD_SET_POS: begin
                    cursor = {3'b000, pos};
                    if (pos < 5'd16)
                        push_byte(1'b0, LCD_DDRAM | {3'b000, pos});
                    else
                        push_byte(1'b0, LCD_DDRAM | ({3'b000, pos} + LINE2_OFFSET));
                end
                CMD_CLEAR: begin
                    push_byte(1'b0, LCD_CLEAR);
                    push_byte(1'b0, LCD_RET_HOME);
                    cursor = 8'd0;
                end
                default: begin
                    push_byte(1'b0, LCD_CGRAM | {2'b00, slot, row});
                    push_byte(1'b1, value);
                end
            endcase
            if (expected_q.size() > start_size)
                expected_q[expected_q.size() - 1].last = 1'b1;
        endfunction

        function void check_nibble(logic rs, logic [3:0] nib, logic last);
            t_lcd_xfer want;
            nibbles_seen++;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: nibble with none expected: rs=%0b nibble=%h last=%0b",
                         $time, rs, nib, last);
                return;
            end
            want = expected_q.pop_front();
            if (rs !== want.rs) begin
                errors++;
                $display("%0t: reg_select expected %0b actual %0b", $time, want.rs, rs);
            end
            if (nib !== want.nib) begin
                errors++;
                $display("%0t: nibble expected %h actual %h", $time, want.nib, nib);
            end
            if (last !== want.last) begin
                errors++;
                $display("%0t: last expected %0b actual %0b", $time, want.last, last);
            end
        endfunction
    endclass

    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_in_valid   = 1'b0;
    logic [1:0] i_cmd        = 2'd0;
    logic [7:0] i_value      = 8'd0;
    logic [4:0] i_position   = 5'd0;
    logic [2:0] i_glyph_slot = 3'd0;
    logic [2:0] i_glyph_row  = 3'd0;
    logic       i_out_stall  = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic       o_reg_select;
    logic [3:0] o_nibble;
    logic       o_last;

    lcd_nibble_scoreboard sb;
    int  cycle_count = 0;
    int  idle_pct    = 20;
    int  stall_pct   = 20;
    bit  hold_req    = 1'b0;
    int  in_stalls   = 0;

    char_lcd_nibble_writer_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_cmd       (i_cmd),
        .i_value     (i_value),
        .i_position  (i_position),
        .i_glyph_slot(i_glyph_slot),
        .i_glyph_row (i_glyph_row),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_reg_select(o_reg_select),
        .o_nibble    (o_nibble),
        .o_last      (o_last)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_nibble(o_reg_select, o_nibble, o_last);
        if (i_rst_n && i_in_valid && o_in_stall)
            in_stalls++;
    end

    initial begin
        wait (cycle_count >= LIMIT);
        $display("Timeout after %0d cycles, %0d nibbles outstanding",
                 cycle_count, sb.pending());
        $display("*** FAILED ***");
        $finish;
    end

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic send_item(t_cmd cmd, logic [7:0] value, logic [4:0] pos,
                             logic [2:0] slot, logic [2:0] row);
        if ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_cmd        <= cmd;
        i_value      <= value;
        i_position   <= pos;
        i_glyph_slot <= slot;
        i_glyph_row  <= row;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_item(cmd, value, pos, slot, row);
    endtask

    task automatic send_print(logic [7:0] ch);
        send_item(CMD_PRINT, ch, 5'($urandom), 3'($urandom), 3'($urandom));
    endtask

    task automatic send_set_pos(logic [4:0] pos);
        send_item(CMD_SET_POS, 8'($urandom), pos, 3'($urandom), 3'($urandom));
    endtask

    task automatic send_clear();
        send_item(CMD_CLEAR, 8'($urandom), 5'($urandom), 3'($urandom), 3'($urandom));
    endtask

    task automatic send_glyph(logic [2:0] slot, logic [2:0] row, logic [7:0] bits);
        send_item(CMD_GLYPH, bits, 5'($urandom), slot, row);
    endtask

    task automatic send_random_item();
        int pick;
        pick = $urandom_range(99);
        if (pick < 8)
            send_print(CHAR_NEWLINE);
        else if (pick < 50)
            send_print(8'($urandom));
        else if (pick < 70)
            send_set_pos(5'($urandom));
        else if (pick < 80)
            send_clear();
        else
            send_glyph(3'($urandom), 3'($urandom), 8'($urandom));
    endtask

    initial begin
        logic [7:0] ch;
        sb = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed corners
        send_print(8'h41);
        send_print(8'h00);
        send_print(8'hFF);
        send_set_pos(5'd15);
        send_print(8'h5A);
        send_set_pos(5'd0);
        send_set_pos(5'd31);
        send_set_pos(5'd16);
        send_clear();
        send_print(CHAR_NEWLINE);
        send_print(8'h42);
        send_print(CHAR_NEWLINE);
        send_print(CHAR_NEWLINE);
        send_clear();
        send_set_pos(5'd5);
        send_print(8'h43);
        send_glyph(3'd7, 3'd7, 8'hFF);
        send_glyph(3'd0, 3'd0, 8'h00);
        send_glyph(3'd5, 3'd2, 8'hA5);
        send_print(CHAR_NEWLINE);
        send_set_pos(5'd15);
        send_print(8'h44);
        send_set_pos(5'd15);
        send_print(CHAR_NEWLINE);
        send_glyph(3'd2, 3'd5, 8'h5A);

        // long print run past cursor 255, no idling, receiver holds off once
        idle_pct  = 0;
        stall_pct = 0;
        hold_req  = 1'b1;
        send_set_pos(5'd16);
        for (int k = 0; k < WRAP_PRINTS; k++) begin
            ch = 8'($urandom);
            if (ch == CHAR_NEWLINE)
                ch = ~ch;
            send_print(ch);
        end
        idle_pct  = 20;
        stall_pct = 20;

        for (int k = 0; k < MIX_ITEMS; k++)
            send_random_item();

        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.pending() != 0) begin
            sb.errors++;
            $display("%0t: %0d expected nibbles never arrived", $time, sb.pending());
        end
        $display("Run covered %0d items and %0d nibbles: %0d line-two jumps,",
                 sb.items_seen, sb.nibbles_seen, sb.line2_jumps);
        $display("  %0d pending clears flushed, %0d input stall cycles, %0d errors",
                 sb.clears_flushed, in_stalls, sb.errors);
        if (sb.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
